FILE: rtl/lhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane histogram steering package
// Shared types, register indexes, reset values and the steering decision.
// ----------------------------------------------------------------------------
package lhs_pkg;

  localparam int MAX_WIDTH_DEF = 512;
  localparam int MAX_ROWS      = 512;
  localparam int COUNT_W       = 10;
  localparam int COL_W         = 9;
  localparam int SPAN_W        = 13;
  localparam int OFFSET_W      = 10;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  localparam logic [9:0] FRAME_WIDTH_RST      = 10'd400;
  localparam logic [8:0] ROI_FIRST_ROW_RST    = 9'd140;
  localparam logic [8:0] ROI_LAST_ROW_RST     = 9'd239;
  localparam logic [9:0] LEFT_BAND_END_RST    = 10'd150;
  localparam logic [8:0] RIGHT_BAND_START_RST = 9'd250;
  localparam logic [8:0] FRAME_CENTER_RST     = 9'd178;

  localparam logic signed [OFFSET_W-1:0] STEER_NEAR  = 10'sd3;
  localparam logic signed [OFFSET_W-1:0] STEER_SMALL = 10'sd5;
  localparam logic signed [OFFSET_W-1:0] STEER_MID   = 10'sd10;
  localparam logic signed [OFFSET_W-1:0] STEER_FAR   = 10'sd20;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH      = 3'd0,
    CFG_ROI_FIRST_ROW    = 3'd1,
    CFG_ROI_LAST_ROW     = 3'd2,
    CFG_LEFT_BAND_END    = 3'd3,
    CFG_RIGHT_BAND_START = 3'd4,
    CFG_FRAME_CENTER     = 3'd5
  } cfg_idx_t;

  typedef enum logic [2:0] {
    STEER_FORWARD = 3'd0,
    STEER_RIGHT_1 = 3'd1,
    STEER_RIGHT_2 = 3'd2,
    STEER_RIGHT_3 = 3'd3,
    STEER_LEFT_1  = 3'd4,
    STEER_LEFT_2  = 3'd5,
    STEER_LEFT_3  = 3'd6,
    STEER_NONE    = 3'd7
  } steer_t;

  typedef struct packed {
    logic [9:0] frame_width;
    logic [8:0] roi_first_row;
    logic [8:0] roi_last_row;
    logic [9:0] left_band_end;
    logic [8:0] right_band_start;
    logic [8:0] frame_center;
  } cfg_t;

  typedef struct packed {
    logic             valid;
    logic [COL_W-1:0] left;
    logic [COL_W-1:0] right;
  } lanes_t;

  typedef struct packed {
    steer_t                steer_code;
    logic [OFFSET_W-1:0]   center_offset;
    logic [COL_W-1:0]      lane_center;
    logic [COL_W-1:0]      right_lane_pos;
    logic [COL_W-1:0]      left_lane_pos;
  } result_t;

  function automatic steer_t steer_of(input logic signed [OFFSET_W-1:0] o);
    steer_t s;
    if (o > -STEER_NEAR && o < STEER_NEAR) begin
      s = STEER_FORWARD;
    end else if (o > STEER_SMALL && o < STEER_MID) begin
      s = STEER_RIGHT_1;
    end else if (o >= STEER_MID && o < STEER_FAR) begin
      s = STEER_RIGHT_2;
    end else if (o > STEER_FAR) begin
      s = STEER_RIGHT_3;
    end else if (o < STEER_SMALL && o > -STEER_MID) begin
      s = STEER_LEFT_1;
    end else if (o < -STEER_MID && o > -STEER_FAR) begin
      s = STEER_LEFT_2;
    end else if (o < -STEER_FAR) begin
      s = STEER_LEFT_3;
    end else begin
      s = STEER_NONE;
    end
    return s;
  endfunction

endpackage

FILE: rtl/lhs_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with the read data registered.
// ----------------------------------------------------------------------------
module lhs_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 512
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/lhs_hist.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Column histogram and peak tracker
// Reads, updates and writes back column counts and tracks the band maxima.
// ----------------------------------------------------------------------------
module lhs_hist
  import lhs_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  cfg_t             cfg,
  input  logic             accept,
  input  logic             pixel_set,
  input  logic [COL_W-1:0] column,
  input  logic [COL_W-1:0] row,
  output lanes_t           lanes,
  output logic [1:0]       pending
);

  localparam int AW = $clog2(MAX_WIDTH);

  logic [SPAN_W-1:0] fw_ext;
  logic [SPAN_W-1:0] eff_w;
  logic              in_region;
  logic              is_emit;
  logic [AW-1:0]     in_addr;

  logic              s1_valid_r, s1_emit_r, s1_first_r, s1_last_r, s1_pix_r;
  logic [COL_W-1:0]  s1_col_r;
  logic [AW-1:0]     s1_addr_r;
  logic              fwd_hit_r;
  logic [COUNT_W-1:0] fwd_cnt_r;
  logic [COUNT_W-1:0] ram_rdata;
  logic [COUNT_W-1:0] base_cnt;
  logic [COUNT_W-1:0] cnt;

  logic [COUNT_W-1:0] lcnt_r, rcnt_r, lcnt_nxt, rcnt_nxt;
  logic [COL_W-1:0]   lcol_r, rcol_r, lcol_nxt, rcol_nxt;
  logic [COUNT_W-1:0] lcnt_base, rcnt_base;
  logic [COL_W-1:0]   lcol_base, rcol_base;
  lanes_t             lanes_r;

  always_comb begin
    fw_ext = SPAN_W'(cfg.frame_width);
    if (fw_ext == '0) begin
      eff_w = SPAN_W'(1);
    end else if (fw_ext > SPAN_W'(MAX_WIDTH)) begin
      eff_w = SPAN_W'(MAX_WIDTH);
    end else begin
      eff_w = fw_ext;
    end
    in_region = (SPAN_W'(column) < eff_w) && (SPAN_W'(row) < SPAN_W'(MAX_ROWS))
             && (row >= cfg.roi_first_row) && (row <= cfg.roi_last_row);
    is_emit   = (row == cfg.roi_last_row) && (SPAN_W'(column) == eff_w - SPAN_W'(1));
    in_addr   = AW'(column);
  end

  lhs_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (MAX_WIDTH)
  ) u_count_ram (
    .clk   (clk),
    .we    (s1_valid_r),
    .waddr (s1_addr_r),
    .wdata (cnt),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s1_emit_r  <= 1'b0;
      fwd_hit_r  <= 1'b0;
    end else begin
      s1_valid_r <= accept && in_region;
      s1_emit_r  <= accept && in_region && is_emit;
      fwd_hit_r  <= s1_valid_r && (s1_addr_r == in_addr);
    end
    s1_first_r <= (row == cfg.roi_first_row);
    s1_last_r  <= (row == cfg.roi_last_row);
    s1_pix_r   <= pixel_set;
    s1_col_r   <= column;
    s1_addr_r  <= in_addr;
    fwd_cnt_r  <= cnt;
  end

  always_comb begin
    base_cnt = fwd_hit_r ? fwd_cnt_r : ram_rdata;
    if (s1_first_r) begin
      cnt = COUNT_W'(s1_pix_r);
    end else if (base_cnt == COUNT_MAX) begin
      cnt = COUNT_MAX;
    end else begin
      cnt = base_cnt + COUNT_W'(s1_pix_r);
    end
  end

  always_comb begin
    if (s1_col_r == '0) begin
      lcnt_base = '0;
      lcol_base = '0;
      rcnt_base = '0;
      rcol_base = cfg.right_band_start;
    end else begin
      lcnt_base = lcnt_r;
      lcol_base = lcol_r;
      rcnt_base = rcnt_r;
      rcol_base = rcol_r;
    end
    lcnt_nxt = lcnt_base;
    lcol_nxt = lcol_base;
    rcnt_nxt = rcnt_base;
    rcol_nxt = rcol_base;
    if (10'(s1_col_r) < cfg.left_band_end && cnt > lcnt_base) begin
      lcnt_nxt = cnt;
      lcol_nxt = s1_col_r;
    end
    if (s1_col_r >= cfg.right_band_start && cnt > rcnt_base) begin
      rcnt_nxt = cnt;
      rcol_nxt = s1_col_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcnt_r        <= '0;
      lcol_r        <= '0;
      rcnt_r        <= '0;
      rcol_r        <= '0;
      lanes_r.valid <= 1'b0;
    end else begin
      if (s1_valid_r && s1_last_r) begin
        lcnt_r <= lcnt_nxt;
        lcol_r <= lcol_nxt;
        rcnt_r <= rcnt_nxt;
        rcol_r <= rcol_nxt;
      end
      lanes_r.valid <= s1_emit_r;
    end
    lanes_r.left  <= lcol_nxt;
    lanes_r.right <= rcol_nxt;
  end

  assign lanes   = lanes_r;
  assign pending = 2'(s1_emit_r) + 2'(lanes_r.valid);

endmodule

FILE: rtl/lhs_steer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane centre and steering output stage
// Forms the centre, offset and steering code and buffers up to two results.
// ----------------------------------------------------------------------------
module lhs_steer
  import lhs_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  lanes_t           lanes,
  input  logic [COL_W-1:0] frame_center,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [39:0]      out_tdata,
  output logic [1:0]       used
);

  logic [OFFSET_W-1:0] diff, diff_adj, half, offset;
  logic [COL_W-1:0]    center;
  result_t             res;
  result_t             out_r, skid_r;
  logic                out_valid_r, skid_valid_r;
  logic                pop;

  always_comb begin
    diff     = {1'b0, lanes.right} - {1'b0, lanes.left};
    diff_adj = diff + OFFSET_W'(diff[OFFSET_W-1]);
    half     = {diff_adj[OFFSET_W-1], diff_adj[OFFSET_W-1:1]};
    center   = COL_W'(half + {1'b0, lanes.left});
    offset   = {1'b0, center} - {1'b0, frame_center};
    res.left_lane_pos  = lanes.left;
    res.right_lane_pos = lanes.right;
    res.lane_center    = center;
    res.center_offset  = offset;
    res.steer_code     = steer_of($signed(offset));
  end

  assign pop = out_valid_r && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (pop || !out_valid_r) begin
      if (skid_valid_r) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= lanes.valid;
      end else begin
        out_valid_r  <= lanes.valid;
      end
    end else if (lanes.valid) begin
      skid_valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop || !out_valid_r) begin
      out_r <= skid_valid_r ? skid_r : res;
    end
    if (lanes.valid && (skid_valid_r || (out_valid_r && !pop))) begin
      skid_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_r;
  assign used       = 2'(out_valid_r) + 2'(skid_valid_r);

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held without an output entry");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(lanes.valid && skid_valid_r && !pop))
    else $error("result arrived with both output entries full");

  a_empty_after_reset: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid_r && !skid_valid_r)
    else $error("output buffer not empty after reset");
`endif

endmodule

FILE: rtl/lane_histogram_steering.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Lane histogram steering
// Column histogram lane finder that reports lane positions and a steering code.
// ----------------------------------------------------------------------------
// After the last pixel of the last region row is accepted, its result passes the
// count RAM read stage, the lane register and the steering output register.
// Throughput: one pixel per cycle; the count RAM read-modify-write forwards
// back-to-back accesses to the same column. Input stalls while two results are in flight.
// Reset: registers return to their defaults and band maxima clear to zero; the
// count RAM is not cleared, as the first region row overwrites every column.
module lane_histogram_steering
  import lhs_pkg::*;
#(
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: pixel_set [0], column [9:1], row [18:10], zero fill [23:19]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,
  // out_tdata: left_lane_pos [8:0], right_lane_pos [17:9], lane_center [26:18],
  // center_offset [36:27], steer_code [39:37]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [9:0]  cfg_data
);

  cfg_t       cfg_r;
  lanes_t     lanes;
  logic [1:0] hist_pending;
  logic [1:0] out_used;
  logic [2:0] in_flight;
  logic       accept;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frame_width      <= FRAME_WIDTH_RST;
      cfg_r.roi_first_row    <= ROI_FIRST_ROW_RST;
      cfg_r.roi_last_row     <= ROI_LAST_ROW_RST;
      cfg_r.left_band_end    <= LEFT_BAND_END_RST;
      cfg_r.right_band_start <= RIGHT_BAND_START_RST;
      cfg_r.frame_center     <= FRAME_CENTER_RST;
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_FRAME_WIDTH:      cfg_r.frame_width      <= cfg_data;
        CFG_ROI_FIRST_ROW:    cfg_r.roi_first_row    <= cfg_data[8:0];
        CFG_ROI_LAST_ROW:     cfg_r.roi_last_row     <= cfg_data[8:0];
        CFG_LEFT_BAND_END:    cfg_r.left_band_end    <= cfg_data;
        CFG_RIGHT_BAND_START: cfg_r.right_band_start <= cfg_data[8:0];
        CFG_FRAME_CENTER:     cfg_r.frame_center     <= cfg_data[8:0];
        default: ;
      endcase
    end
  end

  assign in_flight = 3'(hist_pending) + 3'(out_used);
  assign in_tready = (in_flight < 3'd2);
  assign accept    = in_tvalid && in_tready;

  lhs_hist #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_hist (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .pixel_set (in_tdata[0]),
    .column    (in_tdata[9:1]),
    .row       (in_tdata[18:10]),
    .lanes     (lanes),
    .pending   (hist_pending)
  );

  lhs_steer u_steer (
    .clk          (clk),
    .rst_n        (rst_n),
    .lanes        (lanes),
    .frame_center (cfg_r.frame_center),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .used         (out_used)
  );

endmodule
